[rtl/zpg_pkg.sv]
// ----------------------------------------------------------------------------
// Zone plate generator package
// Shared widths, register map, reset values and the sine table builder.
// ----------------------------------------------------------------------------
package zpg_pkg;

  // Field and port widths
  localparam int FRAME_TIME_W = 15;
  localparam int ROWS_W       = 13;
  localparam int COLS_W       = 13;
  localparam int COORD_W      = 12;
  localparam int LUMA_W       = 8;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  // Parameter defaults
  localparam int PHASE_BITS_DEF     = 12;
  localparam int TIME_FRAC_BITS_DEF = 15;
  localparam int COORD_BITS_DEF     = 12;

  // Magnitude of 60*t*dx and width of dy*dy
  localparam int MAG_W = 32;
  localparam int DSQ_W = 24;

  // Register indexes
  localparam logic [1:0] REG_FRAME_TIME = 2'd0;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [1:0] REG_IMAGE_COLS = 2'd2;

  // Register reset values
  localparam logic [FRAME_TIME_W-1:0] FRAME_TIME_RST = '0;
  localparam logic [ROWS_W-1:0]       ROWS_RST       = 13'd1024;
  localparam logic [COLS_W-1:0]       COLS_RST       = 13'd1920;

  // Luma levels at the quarter turns
  localparam logic [LUMA_W-1:0] LUMA_MID = 8'd127;
  localparam logic [LUMA_W-1:0] LUMA_TOP = 8'd253;
  localparam logic [LUMA_W-1:0] LUMA_BOT = 8'd1;

  // Control word handed along the modulo cells
  typedef struct packed {
    logic vld;
    logic neg;
  } zpg_ctl_t;

  // Integer part of 126*sin for a point m of a quarter wave of 2^(pb-2) steps
  function automatic logic [6:0] sine_whole(int m, int pb);
    real ang;
    ang = 3.141592653589793 * m * (2.0 ** (1 - pb));
    return 7'($rtoi($floor(126.0 * $sin(ang))));
  endfunction

endpackage

[rtl/zone_plate_pixel_generator_core.sv]
// ----------------------------------------------------------------------------
// Zone plate pixel generator
// Returns the luma of a moving zone plate for a pixel's row and column.
// ----------------------------------------------------------------------------
// Throughput: one word a cycle; busy stays low, the modulo and fraction cell rows
// take a new word every cycle.
// Reset: synchronous, active low; registers return to 0, 1024 rows, 1920 columns.
// The receiver cannot stall: each result is shown for one cycle only.
module zone_plate_pixel_generator_core #(
  parameter int PHASE_BITS     = zpg_pkg::PHASE_BITS_DEF,
  parameter int TIME_FRAC_BITS = zpg_pkg::TIME_FRAC_BITS_DEF,
  parameter int COORD_BITS     = zpg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [zpg_pkg::COORD_W-1:0]       in_row_index,
  input  logic [zpg_pkg::COORD_W-1:0]       in_col_index,
  output logic                              out_strobe,
  output logic [zpg_pkg::LUMA_W-1:0]        out_luma,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [zpg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [zpg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [zpg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import zpg_pkg::*;

  localparam int CW        = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << CW) - 1);
  localparam int MOD_STEPS = ((MAG_W - TIME_FRAC_BITS) > DSQ_W) ?
                             (MAG_W - TIME_FRAC_BITS) : DSQ_W;
  localparam int MA_W      = TIME_FRAC_BITS + COLS_W;
  localparam int R_W       = TIME_FRAC_BITS + ROWS_W + COLS_W;

  // Configuration registers
  logic [FRAME_TIME_W-1:0] frame_time_r;
  logic [ROWS_W-1:0]       image_rows_r, rows_eff;
  logic [COLS_W-1:0]       image_cols_r, cols_eff;
  logic                    cfg_wr;

  // Front stages
  logic                    acc;
  logic signed [13:0]      dx_nxt, dy_nxt, dx_r, dy_r;
  logic                    v1_r, v2_r, v3_r;
  logic signed [FRAME_TIME_W-1:0] ft_s;
  logic signed [28:0]      tdx_nxt, tdx_r;
  logic [DSQ_W-1:0]        dsq_nxt, dsq_r, dsq3_r;
  logic signed [34:0]      x60;
  logic [MAG_W-1:0]        mag_nxt, mag_r;
  logic                    neg_r;

  // Modulo cell row
  zpg_ctl_t                ctl_c [MOD_STEPS+1];
  logic [MAG_W-1:0]        ra_c  [MOD_STEPS+1];
  logic [DSQ_W-1:0]        rb_c  [MOD_STEPS+1];
  logic [MA_W-1:0]         ma;

  // Recombination
  logic [MA_W-1:0]         a_fix_nxt, a_fix_r;
  logic [ROWS_W-1:0]       b_fix_r;
  logic                    vfix_r, vprod_r, vred_r;
  logic [R_W-1:0]          pa_nxt, pa_r, pb_nxt, pb_r, den_nxt, den_r;
  logic [25:0]             cb, rc;
  logic [R_W:0]            sum;
  logic [R_W-1:0]          r_nxt, r_r;

  // Fraction cell row
  logic                    vld_f [PHASE_BITS+1];
  logic [R_W-1:0]          r_f   [PHASE_BITS+1];
  logic [PHASE_BITS-1:0]   k_f   [PHASE_BITS+1];

  // Register port: writes complete in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= FRAME_TIME_RST;
      image_rows_r <= ROWS_RST;
      image_cols_r <= COLS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_TIME: frame_time_r <= pwdata[FRAME_TIME_W-1:0];
        REG_IMAGE_ROWS: image_rows_r <= pwdata[ROWS_W-1:0];
        REG_IMAGE_COLS: image_cols_r <= pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_TIME: prdata = CFG_DATA_W'(frame_time_r);
      REG_IMAGE_ROWS: prdata = CFG_DATA_W'(image_rows_r);
      REG_IMAGE_COLS: prdata = CFG_DATA_W'(image_cols_r);
      default:        prdata = '0;
    endcase
  end

  // A zero size counts as one.
  assign rows_eff = (image_rows_r == '0) ? ROWS_W'(1) : image_rows_r;
  assign cols_eff = (image_cols_r == '0) ? COLS_W'(1) : image_cols_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Offsets from the centre.
  assign dx_nxt = $signed({2'b00, in_col_index & COORD_MASK})
                - $signed({2'b00, cols_eff[COLS_W-1:1]});
  assign dy_nxt = $signed({2'b00, in_row_index & COORD_MASK})
                - $signed({2'b00, rows_eff[ROWS_W-1:1]});

  // Time by horizontal offset, and square of the vertical offset.
  assign ft_s    = $signed(frame_time_r);
  assign tdx_nxt = ft_s * dx_r;
  assign dsq_nxt = dy_r * dy_r;

  // Scale by sixty and split into sign and magnitude.
  assign x60     = (35'(tdx_r) <<< 6) - (35'(tdx_r) <<< 2);
  assign mag_nxt = x60[34] ? MAG_W'(-x60) : MAG_W'(x60);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    tdx_r  <= tdx_nxt;
    dsq_r  <= dsq_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= x60[34];
    dsq3_r <= dsq_r;
  end

  // Row of modulo cells: |60*t*dx| mod 2^F*cols and dy*dy mod rows.
  assign ma         = MA_W'(cols_eff) << TIME_FRAC_BITS;
  assign ctl_c[0]   = '{vld: v3_r, neg: neg_r};
  assign ra_c[0]    = mag_r;
  assign rb_c[0]    = dsq3_r;

  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
    zpg_mod_cell #(
      .TIME_FRAC_BITS (TIME_FRAC_BITS),
      .STEPS          (MOD_STEPS),
      .SHIFT          (MOD_STEPS - 1 - g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_c[g]),
      .ra_i  (ra_c[g]),
      .rb_i  (rb_c[g]),
      .ma    (ma),
      .mb    (rows_eff),
      .ctl_o (ctl_c[g+1]),
      .ra_o  (ra_c[g+1]),
      .rb_o  (rb_c[g+1])
    );
  end

  // Floored remainder for a negative product.
  assign a_fix_nxt = (ctl_c[MOD_STEPS].neg && ra_c[MOD_STEPS] != '0) ?
                     MA_W'(ma - MA_W'(ra_c[MOD_STEPS])) : MA_W'(ra_c[MOD_STEPS]);

  // Both terms over the common denominator.
  assign pa_nxt  = rows_eff * a_fix_r;
  assign cb      = cols_eff * b_fix_r;
  assign pb_nxt  = R_W'(cb) << TIME_FRAC_BITS;
  assign rc      = rows_eff * cols_eff;
  assign den_nxt = R_W'(rc) << TIME_FRAC_BITS;

  // Sum below twice the denominator: one conditional subtract.
  assign sum   = {1'b0, pa_r} + {1'b0, pb_r};
  assign r_nxt = (sum >= {1'b0, den_r}) ? R_W'(sum - {1'b0, den_r}) : R_W'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfix_r  <= 1'b0;
      vprod_r <= 1'b0;
      vred_r  <= 1'b0;
    end else begin
      vfix_r  <= ctl_c[MOD_STEPS].vld;
      vprod_r <= vfix_r;
      vred_r  <= vprod_r;
    end
  end

  always_ff @(posedge clk) begin
    a_fix_r <= a_fix_nxt;
    b_fix_r <= ROWS_W'(rb_c[MOD_STEPS]);
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    den_r   <= den_nxt;
    r_r     <= r_nxt;
  end

  // Row of fraction cells: one index bit per cell.
  assign vld_f[0] = vred_r;
  assign r_f[0]   = r_r;
  assign k_f[0]   = '0;

  for (genvar g = 0; g < PHASE_BITS; g++) begin : g_frac
    zpg_frac_cell #(
      .TIME_FRAC_BITS (TIME_FRAC_BITS),
      .PHASE_BITS     (PHASE_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_f[g]),
      .r_i   (r_f[g]),
      .k_i   (k_f[g]),
      .den   (den_r),
      .vld_o (vld_f[g+1]),
      .r_o   (r_f[g+1]),
      .k_o   (k_f[g+1])
    );
  end

  // Sine lookup and output word.
  zpg_sine_rom #(
    .PHASE_BITS (PHASE_BITS)
  ) u_rom (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_f[PHASE_BITS]),
    .k_i    (k_f[PHASE_BITS]),
    .vld_o  (out_strobe),
    .luma_o (out_luma)
  );

  // The output word stays within the sine swing.
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_luma >= LUMA_BOT && out_luma <= LUMA_TOP))
    else $error("luma word outside the sine swing");

  // The floored remainder stays below its modulus.
  a_fix_below: assert property (@(posedge clk) disable iff (!rst_n)
    vfix_r |-> (a_fix_r < ma))
    else $error("horizontal remainder not reduced");

  // The phase remainder stays below the denominator.
  a_red_below: assert property (@(posedge clk) disable iff (!rst_n)
    vprod_r |=> (r_r < den_r))
    else $error("phase remainder not reduced");

endmodule

[rtl/zpg_mod_cell.sv]
// ----------------------------------------------------------------------------
// Zone plate modulo cell
// One restoring step of two remainders at a fixed shift, registered.
// ----------------------------------------------------------------------------
module zpg_mod_cell #(
  parameter int TIME_FRAC_BITS = zpg_pkg::TIME_FRAC_BITS_DEF,
  parameter int STEPS          = 24,
  parameter int SHIFT          = 0
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  zpg_pkg::zpg_ctl_t                            ctl_i,
  input  logic [zpg_pkg::MAG_W-1:0]                    ra_i,
  input  logic [zpg_pkg::DSQ_W-1:0]                    rb_i,
  input  logic [TIME_FRAC_BITS+zpg_pkg::COLS_W-1:0]    ma,
  input  logic [zpg_pkg::ROWS_W-1:0]                   mb,
  output zpg_pkg::zpg_ctl_t                            ctl_o,
  output logic [zpg_pkg::MAG_W-1:0]                    ra_o,
  output logic [zpg_pkg::DSQ_W-1:0]                    rb_o
);
  import zpg_pkg::*;

  localparam int MA_W = TIME_FRAC_BITS + COLS_W;
  localparam int EA_W = MA_W + STEPS;
  localparam int EB_W = ROWS_W + STEPS;

  logic [EA_W-1:0]  sa, ea;
  logic [EB_W-1:0]  sb, eb;
  logic [MAG_W-1:0] ra_nxt, ra_r;
  logic [DSQ_W-1:0] rb_nxt, rb_r;
  zpg_ctl_t         ctl_r;

  // Subtract the shifted modulus where it fits.
  always_comb begin
    sa = EA_W'(ma) << SHIFT;
    ea = EA_W'(ra_i);
    sb = EB_W'(mb) << SHIFT;
    eb = EB_W'(rb_i);
    ra_nxt = (ea >= sa) ? MAG_W'(ea - sa) : ra_i;
    rb_nxt = (eb >= sb) ? DSQ_W'(eb - sb) : rb_i;
  end

  // Control word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // Remainders.
  always_ff @(posedge clk) begin
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
  end

  assign ctl_o = ctl_r;
  assign ra_o  = ra_r;
  assign rb_o  = rb_r;

endmodule

[rtl/zpg_frac_cell.sv]
// ----------------------------------------------------------------------------
// Zone plate fraction cell
// One restoring division step giving the next phase index bit.
// ----------------------------------------------------------------------------
module zpg_frac_cell #(
  parameter int TIME_FRAC_BITS = zpg_pkg::TIME_FRAC_BITS_DEF,
  parameter int PHASE_BITS     = zpg_pkg::PHASE_BITS_DEF
) (
  input  logic                                                         clk,
  input  logic                                                         rst_n,
  input  logic                                                         vld_i,
  input  logic [TIME_FRAC_BITS+zpg_pkg::ROWS_W+zpg_pkg::COLS_W-1:0]    r_i,
  input  logic [PHASE_BITS-1:0]                                        k_i,
  input  logic [TIME_FRAC_BITS+zpg_pkg::ROWS_W+zpg_pkg::COLS_W-1:0]    den,
  output logic                                                         vld_o,
  output logic [TIME_FRAC_BITS+zpg_pkg::ROWS_W+zpg_pkg::COLS_W-1:0]    r_o,
  output logic [PHASE_BITS-1:0]                                        k_o
);
  import zpg_pkg::*;

  localparam int R_W = TIME_FRAC_BITS + ROWS_W + COLS_W;

  logic [R_W:0]          r2, d2;
  logic                  bit_nxt;
  logic [R_W-1:0]        r_nxt, r_r;
  logic [PHASE_BITS-1:0] k_nxt, k_r;
  logic                  vld_r;

  // Double the remainder and take off the denominator where it fits.
  always_comb begin
    r2      = {r_i, 1'b0};
    d2      = {1'b0, den};
    bit_nxt = (r2 >= d2);
    r_nxt   = bit_nxt ? R_W'(r2 - d2) : R_W'(r2);
    k_nxt   = {k_i[PHASE_BITS-2:0], bit_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    k_r <= k_nxt;
  end

  assign vld_o = vld_r;
  assign r_o   = r_r;
  assign k_o   = k_r;

endmodule

[rtl/zpg_sine_rom.sv]
// ----------------------------------------------------------------------------
// Zone plate sine lookup
// Quarter-wave sine table with folding and a registered luma word.
// ----------------------------------------------------------------------------
module zpg_sine_rom #(
  parameter int PHASE_BITS = zpg_pkg::PHASE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic [PHASE_BITS-1:0]        k_i,
  output logic                         vld_o,
  output logic [zpg_pkg::LUMA_W-1:0]   luma_o
);
  import zpg_pkg::*;

  localparam int QUARTER = 1 << (PHASE_BITS - 2);
  localparam int IDX_W   = PHASE_BITS - 1;

  logic [6:0]        tbl [QUARTER+1];
  logic [1:0]        quad;
  logic [IDX_W-1:0]  m_nxt, m_r;
  logic              neg_r, zero_r, quart_r, vld1_r;
  logic              neg2_r, zero2_r, quart2_r, vld2_r;
  logic [6:0]        whole_r;
  logic [LUMA_W-1:0] luma_nxt, luma_r;
  logic              vld3_r;

  // Table contents fixed at elaboration.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
    assign tbl[g] = sine_whole(g, PHASE_BITS);
  end

  // Fold the index into the first quarter.
  always_comb begin
    quad  = k_i[PHASE_BITS-1:PHASE_BITS-2];
    m_nxt = quad[0] ? IDX_W'(QUARTER) - IDX_W'(k_i[PHASE_BITS-3:0])
                    : IDX_W'(k_i[PHASE_BITS-3:0]);
  end

  // Rebuild the luma word around the mid level.
  always_comb begin
    if (zero2_r) begin
      luma_nxt = LUMA_MID;
    end else if (quart2_r) begin
      luma_nxt = neg2_r ? LUMA_BOT : LUMA_TOP;
    end else if (neg2_r) begin
      luma_nxt = LUMA_MID - 8'd1 - LUMA_W'(whole_r);
    end else begin
      luma_nxt = LUMA_MID + LUMA_W'(whole_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    neg_r    <= quad[1];
    zero_r   <= (m_nxt == '0);
    quart_r  <= (m_nxt == IDX_W'(QUARTER));
    whole_r  <= tbl[m_r];
    neg2_r   <= neg_r;
    zero2_r  <= zero_r;
    quart2_r <= quart_r;
    luma_r   <= luma_nxt;
  end

  assign vld_o  = vld3_r;
  assign luma_o = luma_r;

endmodule

[tb/zone_plate_pixel_generator_core_tb.sv]
// ----------------------------------------------------------------------------
// Zone plate pixel generator testbench
// Drives pixel coordinates and register writes into the generator and checks
// every luma word against a predictor built on exact integer phase arithmetic.
// ----------------------------------------------------------------------------
module zone_plate_pixel_generator_core_tb;
  import zpg_pkg::*;

  localparam int PB        = PHASE_BITS_DEF;
  localparam int TFB       = TIME_FRAC_BITS_DEF;
  localparam int DRAIN_CYC = 60;
  localparam int CYC_LIMIT = 400000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [COORD_W-1:0]      in_row_index = '0;
  logic [COORD_W-1:0]      in_col_index = '0;
  logic                    out_strobe;
  logic [LUMA_W-1:0]       out_luma;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  // Predictor copy of the registers.
  logic [FRAME_TIME_W-1:0] pred_time;
  logic [ROWS_W-1:0]       pred_rows;
  logic [COLS_W-1:0]       pred_cols;

  logic [LUMA_W-1:0]       luma_queue[$];
  int                      errors = 0;
  int                      idle_pct = 0;
  int                      cycles = 0;

  zone_plate_pixel_generator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .out_strobe(out_strobe), .out_luma(out_luma),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Sine table word for a phase index, taken from a quarter wave.
  function automatic logic [LUMA_W-1:0] sine_luma(longint k);
    longint quarter, quad, q, m;
    real    ang;
    int     whole;
    quarter = longint'(1) << (PB - 2);
    quad = (k >> (PB - 2)) & 3;
    q = k & (quarter - 1);
    m = quad[0] ? quarter - q : q;
    if (m == 0) return LUMA_MID;
    if (m == quarter) return (quad >= 2) ? LUMA_BOT : LUMA_TOP;
    ang = 3.141592653589793 * real'(m) / (2.0 ** (PB - 1));
    whole = $rtoi($floor(126.0 * $sin(ang)));
    return (quad >= 2) ? LUMA_W'(126 - whole) : LUMA_W'(127 + whole);
  endfunction

  // Luma of the zone plate at one pixel, from the exact rational phase.
  function automatic logic [LUMA_W-1:0] zone_luma(logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
    longint rows, cols, t, dx, dy, den, num, rem, k;
    rows = (pred_rows == 0) ? 1 : longint'(pred_rows);
    cols = (pred_cols == 0) ? 1 : longint'(pred_cols);
    t = longint'($signed(pred_time));
    dx = longint'(col) - cols / 2;
    dy = longint'(row) - rows / 2;
    den = (longint'(1) << TFB) * cols * rows;
    num = 60 * t * dx * rows + dy * dy * (longint'(1) << TFB) * cols;
    rem = num % den;
    if (rem < 0) rem += den;
    k = (rem << PB) / den;
    return sine_luma(k);
  endfunction

  // Compare each luma word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (luma_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual luma %0d", $time, out_luma);
        errors++;
      end else begin
        if (out_luma !== luma_queue[0]) begin
          $display("%0t: luma mismatch, expected %0d, actual %0d",
                   $time, luma_queue[0], out_luma);
          errors++;
        end
        void'(luma_queue.pop_front());
      end
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one pixel after random idle cycles and hold it until accepted.
  task automatic send_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_row_index = row;
    in_col_index = col;
    do @(posedge clk); while (busy);
    luma_queue.push_back(zone_luma(row, col));
  endtask

  // Let the pipeline empty out.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (luma_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Register write over the configuration port; the block is idle here.
  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = CFG_ADDR_W'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAME_TIME: pred_time = val[FRAME_TIME_W-1:0];
      REG_IMAGE_ROWS: pred_rows = val[ROWS_W-1:0];
      REG_IMAGE_COLS: pred_cols = val[COLS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_picture(int t, int rows, int cols);
    write_reg(REG_FRAME_TIME, CFG_DATA_W'(t));
    write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_IMAGE_COLS, CFG_DATA_W'(cols));
  endtask

  // Corners, centre, quarter turns and the time extremes.
  task automatic test_directed();
    send_pixel(12'd512, 12'd960);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    set_picture(0, 4, 2);
    send_pixel(12'd3, 12'd1);
    send_pixel(12'd2, 12'd1);
    send_pixel(12'hFFF, 12'hFFF);
    write_reg(REG_IMAGE_ROWS, 12);
    send_pixel(12'd9, 12'd1);
    send_pixel(12'd3, 12'd0);
    set_picture(-16384, 4096, 4096);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hAAA, 12'h555);
    set_picture(16383, 2, 2);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd1, 12'd1);
    set_picture(16383, 4096, 2);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd2048, 12'd1);
  endtask

  // Random pixels over a run of random and extreme pictures.
  task automatic test_random(int n_words);
    int n;
    for (n = 0; n < n_words; n++) begin
      if (n % 50 == 0) begin
        case ((n / 50) % 4)
          0: set_picture($urandom_range(32767) - 16384, 2, 4096);
          1: set_picture(16383, 4096, $urandom_range(2, 4096));
          default: set_picture($urandom_range(32767) - 16384,
                               $urandom_range(2, 4096), $urandom_range(2, 4096));
        endcase
      end
      send_pixel(COORD_W'($urandom_range(4095)), COORD_W'($urandom_range(4095)));
    end
  endtask

  initial begin
    pred_time = FRAME_TIME_RST;
    pred_rows = ROWS_RST;
    pred_cols = COLS_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_pct = 0;
    test_directed();
    idle_pct = 0;
    test_random(150);
    idle_pct = 88;
    test_random(150);
    idle_pct = 20;
    test_random(250);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
